[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[src/ctv_pkg.sv]
// ----------------------------------------------------------------------------
// ctv_pkg
// Types and constants of the CDF table validator.
// ----------------------------------------------------------------------------
package ctv_pkg;

    localparam int unsigned MAX_TABLE_WORDS = 65536;
    // Word counter holds values up to MAX_TABLE_WORDS + 1 (overflow marker).
    localparam int unsigned TW_W = $clog2(MAX_TABLE_WORDS + 2);

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LEN_W   = 17;
    localparam int unsigned ROW_W   = 15;
    localparam int unsigned PREC_W  = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] MIN_ROW_LENGTH   = LEN_W'(3);
    localparam logic [LEN_W-1:0] WORDS_SAT        = '1;
    localparam logic [PREC_W-1:0] MAX_PRECISION   = PREC_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYOUT_MODE = 1'b0,
        CFG_ROW_LENGTH  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_PREC = 2'd0,
        PH_ZERO = 2'd1,
        PH_VAL  = 2'd2,
        PH_PAD  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_PREMATURE = 3'd1,
        ERR_PREC      = 3'd2,
        ERR_NO_ZERO   = 3'd3,
        ERR_MONOTONIC = 3'd4,
        ERR_NO_TERM   = 3'd5,
        ERR_TOO_LONG  = 3'd6
    } t_err;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic              row_done;
        logic [LEN_W-1:0]  row_words;
        logic [PREC_W-1:0] row_precision;
        logic              row_escape;
        t_err              error_code;
        logic              table_done;
    } t_out_item;

endpackage

[src/ctv_in_if.sv]
// ----------------------------------------------------------------------------
// ctv_in_if
// Valid/ready channel carrying one table word per transfer.
// ----------------------------------------------------------------------------
interface ctv_in_if import ctv_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ctv_out_if.sv]
// ----------------------------------------------------------------------------
// ctv_out_if
// Valid/ready channel carrying one row report per transfer.
// ----------------------------------------------------------------------------
interface ctv_out_if import ctv_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/cdf_table_validator_unit.sv]
// Each input transfer loads its report into the output register, which presents it in the following cycle.
// Throughput: one table word per cycle while reports are taken; the row state (phase, last value, counts)
// is updated in a single pass per word and the output register refills while
// the previous report is being taken.
// Reset (i_rst_n low, synchronous) empties the output register, returns the
// parser to "expect precision word" and loads layout_mode 0, row_length 64.
// ----------------------------------------------------------------------------
// cdf_table_validator_unit
// Streams a packed table of cumulative-frequency rows, checks every row and
// reports row index, length, precision and escape flag per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdf_table_validator_unit import ctv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctv_in_if.sink               i_in,
    ctv_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             r_layout_mode;
    logic [LEN_W-1:0] r_row_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_mode <= 1'b0;
            r_row_length  <= ROW_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LAYOUT_MODE: r_layout_mode <= i_cfg_data[0];
                CFG_ROW_LENGTH:  r_row_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase                    r_phase,      n_phase;
    logic signed [WORD_W-1:0]  r_prev,       n_prev;
    logic [LEN_W-1:0]          r_target,     n_target;
    logic [PREC_W-1:0]         r_precision,  n_precision;
    logic                      r_escape,     n_escape;
    logic [LEN_W-1:0]          r_row_words,  n_row_words;
    logic [LEN_W-1:0]          r_row_pos,    n_row_pos;
    logic [ROW_W-1:0]          r_row_count,  n_row_count;
    t_err                      r_pending,    n_pending;
    t_err                      r_sticky,     n_sticky;
    logic [TW_W-1:0]           r_table_words, n_table_words;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    logic in_fire;

    // Accept whenever the output register is empty or being drained.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // ------------------------------------------------------------------
    // Per-word decode
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  w;
    logic               last;
    logic               matrix;
    logic               row_end;
    logic               at_end;
    logic               prec_ok;
    logic [PREC_W-1:0]  prec_mag;
    logic               is_target;
    logic               too_long;
    logic               prec_short;

    assign w      = i_in.data.word;
    assign last   = i_in.data.last;
    assign matrix = r_layout_mode;

    // Last word of a matrix row when position + 1 reaches row_length.
    assign row_end = ({1'b0, r_row_pos} + (LEN_W+1)'(1)) >= {1'b0, r_row_length};
    assign at_end  = matrix ? row_end : last;

    // Precision magnitude 1..16, either sign.
    assign prec_ok  = w[WORD_W-1] ? ($signed(w) >= -32'sd16)
                                  : ((w != '0) && (w <= WORD_W'(MAX_PRECISION)));
    assign prec_mag = w[WORD_W-1] ? PREC_W'(~w[PREC_W-1:0] + PREC_W'(1))
                                  : w[PREC_W-1:0];

    assign is_target  = (w == WORD_W'(r_target));
    assign too_long   = n_table_words > TW_W'(MAX_TABLE_WORDS);
    // A row that cannot hold its precision, zero and terminal words is cut short.
    assign prec_short = at_end || (matrix && (r_row_length < MIN_ROW_LENGTH));

    // Saturating table word count
    always_comb begin
        n_table_words = r_table_words;
        if (r_table_words <= TW_W'(MAX_TABLE_WORDS)) begin
            n_table_words = r_table_words + TW_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Next state and report
    // ------------------------------------------------------------------
    always_comb begin
        t_err             e;
        logic             take_prec;
        logic [ROW_W-1:0] idx;
        logic             done;
        logic [LEN_W-1:0] rw;
        logic [PREC_W-1:0] rp;
        logic             re;

        e         = ERR_OK;
        take_prec = 1'b0;
        idx       = r_row_count;
        done      = 1'b0;
        rw        = '0;
        rp        = '0;
        re        = 1'b0;

        n_phase     = r_phase;
        n_prev      = r_prev;
        n_target    = r_target;
        n_precision = r_precision;
        n_escape    = r_escape;
        n_row_words = r_row_words;
        n_row_pos   = r_row_pos;
        n_row_count = r_row_count;
        n_pending   = r_pending;
        n_sticky    = r_sticky;

        if (r_sticky == ERR_OK) begin
            if (too_long) begin
                e = ERR_TOO_LONG;
            end else if (matrix && last && !row_end) begin
                e = ERR_PREMATURE;
            end else begin
                case (r_phase)
                    PH_PREC: begin
                        take_prec = 1'b1;
                    end
                    PH_ZERO: begin
                        if (at_end) begin
                            e = ERR_PREMATURE;
                        end else if (r_pending != ERR_OK) begin
                            e = r_pending;
                        end else if (w != '0) begin
                            e = ERR_NO_ZERO;
                        end else begin
                            n_prev = '0;
                            if (r_row_words < WORDS_SAT) begin
                                n_row_words = r_row_words + LEN_W'(1);
                            end
                            n_phase = PH_VAL;
                        end
                        n_pending = ERR_OK;
                    end
                    PH_VAL: begin
                        if (r_row_words < WORDS_SAT) begin
                            n_row_words = r_row_words + LEN_W'(1);
                        end
                        if ($signed(w) < r_prev) begin
                            e = ERR_MONOTONIC;
                        end else if (is_target) begin
                            // Terminal closes the row.
                            done        = 1'b1;
                            rw          = n_row_words;
                            rp          = r_precision;
                            re          = r_escape;
                            n_row_count = r_row_count + ROW_W'(1);
                            n_phase     = (matrix && at_end) ? PH_PREC : PH_PAD;
                        end else if (at_end) begin
                            e = ERR_NO_TERM;
                        end else begin
                            n_prev = $signed(w);
                        end
                    end
                    PH_PAD: begin
                        if (is_target) begin
                            // Padding reports against the row just closed.
                            idx = r_row_count - ROW_W'(1);
                            if (matrix && at_end) begin
                                n_phase = PH_PREC;
                            end
                        end else if (matrix) begin
                            e = ERR_NO_TERM;
                        end else begin
                            take_prec = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // Precision word opens a new row.
                if (take_prec) begin
                    if (prec_short) begin
                        e = ERR_PREMATURE;
                    end else begin
                        if (prec_ok) begin
                            n_pending   = ERR_OK;
                            n_precision = prec_mag;
                            n_target    = LEN_W'(1) << prec_mag;
                        end else begin
                            // Hold the range error until the zero word.
                            n_pending   = ERR_PREC;
                            n_precision = '0;
                            n_target    = '0;
                        end
                        n_escape    = w[WORD_W-1];
                        n_row_words = LEN_W'(1);
                        n_phase     = PH_ZERO;
                    end
                end
            end

            if (e == ERR_OK) begin
                n_row_pos = (matrix && !row_end) ? r_row_pos + LEN_W'(1) : '0;
            end else begin
                n_sticky = e;
                done     = 1'b0;
                rw       = '0;
                rp       = '0;
                re       = 1'b0;
                idx      = r_row_count;
            end
        end

        n_out_data.row_index     = idx;
        n_out_data.row_done      = done;
        n_out_data.row_words     = rw;
        n_out_data.row_precision = rp;
        n_out_data.row_escape    = re;
        n_out_data.error_code    = n_sticky;
        n_out_data.table_done    = last;
    end

    // ------------------------------------------------------------------
    // State registers: drop everything back to reset after the last word.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_fire && last)) begin
            r_phase       <= PH_PREC;
            r_prev        <= '0;
            r_target      <= '0;
            r_precision   <= '0;
            r_escape      <= 1'b0;
            r_row_words   <= '0;
            r_row_pos     <= '0;
            r_row_count   <= '0;
            r_pending     <= ERR_OK;
            r_sticky      <= ERR_OK;
            r_table_words <= '0;
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_prev        <= n_prev;
            r_target      <= n_target;
            r_precision   <= n_precision;
            r_escape      <= n_escape;
            r_row_words   <= n_row_words;
            r_row_pos     <= n_row_pos;
            r_row_count   <= n_row_count;
            r_pending     <= n_pending;
            r_sticky      <= n_sticky;
            r_table_words <= n_table_words;
        end
    end

    // Output register: load on an input transfer, clear once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_done_no_error, i_clk, i_rst_n,
        (r_out_valid && r_out_data.row_done) |-> (r_out_data.error_code == ERR_OK))
    `ASSERT_CLK(a_fields_only_with_done, i_clk, i_rst_n,
        (r_out_valid && !r_out_data.row_done) |->
            (r_out_data.row_words == '0 && r_out_data.row_precision == '0 &&
             !r_out_data.row_escape))
    `ASSERT_CLK(a_sticky_holds, i_clk, i_rst_n,
        (in_fire && !i_in.data.last && r_sticky != ERR_OK) |=>
            (r_sticky == $past(r_sticky)))
    `ASSERT_CLK(a_table_end_clears, i_clk, i_rst_n,
        (in_fire && i_in.data.last) |=>
            (r_phase == PH_PREC && r_sticky == ERR_OK && r_table_words == '0))

endmodule
